// ----- hw/rtl/jss_pkg.sv -----
// jss_pkg: shared types, reset constants and helpers of the joystick stepper sequencer
// used by jss_ctrl, jss_datapath and joystick_stepper_sequencer_unit
`default_nettype none

package jss_pkg;

    localparam int unsigned PHASE_COUNT_DEF = 8;
    localparam int unsigned SAMPLE_W        = 8;
    localparam int unsigned COIL_W          = 4;
    localparam int unsigned DELAY_W         = 18;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned CFG_DATA_W      = 32;
    localparam int unsigned SQ_W            = 2 * SAMPLE_W;
    localparam int unsigned PROD_W          = SQ_W + SAMPLE_W;

    localparam logic [SAMPLE_W-1:0]   HIGH_TH_RST = 8'h90;
    localparam logic [SAMPLE_W-1:0]   LOW_TH_RST  = 8'h70;
    localparam logic [SAMPLE_W-1:0]   SCALE_RST   = 8'd10;
    localparam logic [CFG_DATA_W-1:0] PATTERN_RST = 32'h1248_1248;
    localparam logic [DELAY_W-1:0]    DELAY_MAX   = {DELAY_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_TH = 2'd0,
        CFG_LOW_TH  = 2'd1,
        CFG_SCALE   = 2'd2,
        CFG_PATTERN = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQUARE,
        S_SCALE
    } t_state;

    typedef struct packed {
        logic take;
        logic square;
        logic scale;
    } t_dp_cmd;

    typedef struct packed {
        logic delay_zero;
        logic step_hit;
        logic out_free;
    } t_dp_sts;

    // coil port order: pattern bits 1 and 2 change places
    function automatic logic [COIL_W-1:0] swap_mid_bits(input logic [COIL_W-1:0] p);
        swap_mid_bits = {p[3], p[1], p[2], p[0]};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jss_ctrl.sv -----
// jss_ctrl: sequencing state machine of the joystick stepper sequencer
// depends on jss_pkg; drives jss_datapath through t_dp_cmd
`default_nettype none

module jss_ctrl
    import jss_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.take && i_sts.delay_zero && i_sts.step_hit) begin
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: n_state = S_SCALE;
            S_SCALE:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall      = 1'b1;
        o_cmd.take   = 1'b0;
        o_cmd.square = 1'b0;
        o_cmd.scale  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall    = !i_sts.out_free;
                o_cmd.take = i_valid && i_sts.out_free;
            end
            S_SQUARE: o_cmd.square = 1'b1;
            S_SCALE:  o_cmd.scale  = 1'b1;
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

`ifndef SYNTH
    a_square_then_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQUARE |=> r_state == S_SCALE)
        else $error("squaring not followed by scaling");

    a_step_starts_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_sts.delay_zero && i_sts.step_hit) |=> r_state == S_SQUARE)
        else $error("step did not start the delay computation");

    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> (!o_cmd.take && o_stall))
        else $error("transfer taken during delay computation");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/jss_datapath.sv -----
// jss_datapath: configuration, phase, coil and delay registers, delay multiplier
// depends on jss_pkg; commanded by jss_ctrl
`default_nettype none

module jss_datapath
    import jss_pkg::*;
#(
    parameter int unsigned PHASE_COUNT = PHASE_COUNT_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire  [SAMPLE_W-1:0]    i_adc_sample,
    input  wire                    i_out_stall,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    output logic                   o_out_valid,
    output logic [COIL_W-1:0]      o_coil_drive,
    output logic                   o_stepped,
    output logic                   o_stopped,
    output logic                   o_turn_direction
);

    localparam int unsigned PHASE_W = (PHASE_COUNT > 2) ? $clog2(PHASE_COUNT) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASE_COUNT - 1);

    logic [SAMPLE_W-1:0]   r_high_th;
    logic [SAMPLE_W-1:0]   r_low_th;
    logic [SAMPLE_W-1:0]   r_scale;
    logic [CFG_DATA_W-1:0] r_pattern;

    logic [PHASE_W-1:0]    r_phase;
    logic [DELAY_W-1:0]    r_delay;
    logic [COIL_W-1:0]     r_coil;
    logic                  r_dir;

    logic [SAMPLE_W-1:0]   r_dist;
    logic [SQ_W-1:0]       r_sq;

    logic                  r_out_valid;
    logic                  r_stepped;
    logic                  r_stopped;

    logic                  hit_cw;
    logic                  hit_ccw;
    logic [SAMPLE_W-1:0]   excess;
    logic [2:0]            nib_sel;
    logic [COIL_W-1:0]     nibble;
    logic                  step_dir;
    logic [PHASE_W-1:0]    phase_next;
    logic [PROD_W-1:0]     prod;
    logic [DELAY_W-1:0]    delay_sat;

    // clockwise test wins when the thresholds overlap
    always_comb begin
        hit_cw   = i_adc_sample >= r_high_th;
        hit_ccw  = i_adc_sample <= r_low_th;
        step_dir = !hit_cw;
        excess   = hit_cw ? (i_adc_sample - r_high_th) : (r_low_th - i_adc_sample);
        nib_sel  = 3'(r_phase);
        nibble   = r_pattern[nib_sel*COIL_W +: COIL_W];
        if (!step_dir) begin
            phase_next = (r_phase == PHASE_LAST) ? '0 : r_phase + 1'b1;
        end else begin
            phase_next = (r_phase == '0) ? PHASE_LAST : r_phase - 1'b1;
        end
        prod      = r_scale * r_sq;
        delay_sat = (|prod[PROD_W-1:DELAY_W]) ? DELAY_MAX : prod[DELAY_W-1:0];
    end

    always_comb begin
        o_sts.delay_zero = (r_delay == '0);
        o_sts.step_hit   = hit_cw || hit_ccw;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_th <= HIGH_TH_RST;
            r_low_th  <= LOW_TH_RST;
            r_scale   <= SCALE_RST;
            r_pattern <= PATTERN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HIGH_TH: r_high_th <= i_cfg_data[SAMPLE_W-1:0];
                CFG_LOW_TH:  r_low_th  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_SCALE:   r_scale   <= i_cfg_data[SAMPLE_W-1:0];
                CFG_PATTERN: r_pattern <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_delay <= '0;
            r_coil  <= '0;
            r_dir   <= 1'b0;
        end else if (i_cmd.take) begin
            if (r_delay != '0) begin
                r_delay <= r_delay - 1'b1;
            end else if (hit_cw || hit_ccw) begin
                r_dir   <= step_dir;
                r_coil  <= swap_mid_bits(nibble);
                r_phase <= phase_next;
            end
        end else if (i_cmd.scale) begin
            r_delay <= delay_sat;
        end
    end

    // squared distance settles while the state machine holds off new samples
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_dist <= excess;
        end
        if (i_cmd.square) begin
            r_sq <= r_dist * r_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_stepped <= (r_delay == '0) && (hit_cw || hit_ccw);
            r_stopped <= (r_delay == '0) && !(hit_cw || hit_ccw);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_coil_drive     = r_coil;
    assign o_stepped        = r_stepped;
    assign o_stopped        = r_stopped;
    assign o_turn_direction = r_dir;

`ifndef SYNTH
    a_step_or_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_stepped && r_stopped))
        else $error("result both stepped and stopped");

    a_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take && r_delay != '0) |=> r_delay == $past(r_delay) - 1'b1)
        else $error("delay counter did not count down");

    a_phase_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take && r_delay != '0) |=> $stable(r_phase) && $stable(r_coil))
        else $error("phase moved during a pending delay");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/joystick_stepper_sequencer_unit.sv -----
// joystick_stepper_sequencer_unit: top level of the joystick stepper sequencer
// depends on jss_pkg, jss_ctrl and jss_datapath
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------------------
//   sample   | in        | i_valid / o_stall   | i_adc_sample
//   result   | out       | o_valid / i_stall   | o_coil_drive, o_stepped, o_stopped,
//            |           |                     | o_turn_direction
//   config   | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// a sample taken while a delay is pending or inside the dead band leaves the unit idle
// a step computes the delay as scale * r * r through two registered multiplies,
// squaring then scaling, before the next sample is taken
// a held result stalls the sample side until it leaves; both may transfer in one cycle
// synchronous active-low reset restores register defaults, phase 0, no delay, coils off
`default_nettype none

module joystick_stepper_sequencer_unit
    import jss_pkg::*;
#(
    parameter int unsigned PHASE_COUNT = PHASE_COUNT_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire  [SAMPLE_W-1:0]    i_adc_sample,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic [COIL_W-1:0]      o_coil_drive,
    output logic                   o_stepped,
    output logic                   o_stopped,
    output logic                   o_turn_direction,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    jss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    jss_datapath #(
        .PHASE_COUNT (PHASE_COUNT)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_adc_sample     (i_adc_sample),
        .i_out_stall      (i_stall),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_valid),
        .o_coil_drive     (o_coil_drive),
        .o_stepped        (o_stepped),
        .o_stopped        (o_stopped),
        .o_turn_direction (o_turn_direction)
    );

endmodule

`default_nettype wire

// ----- tb/sv/jss_sequence_checker.sv -----
// jss_sequence_checker: predicts and checks every result of the joystick stepper sequencer
// watches the sample, result and register write ports; depends on jss_pkg only
`default_nettype none

module jss_sequence_checker
    import jss_pkg::*;
#(
    parameter int unsigned PHASE_COUNT = PHASE_COUNT_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_smp_valid,
    input  wire                   i_smp_stall,
    input  wire  [SAMPLE_W-1:0]   i_smp_data,
    input  wire                   i_res_valid,
    input  wire                   i_res_stall,
    input  wire  [COIL_W-1:0]     i_res_coil_drive,
    input  wire                   i_res_stepped,
    input  wire                   i_res_stopped,
    input  wire                   i_res_turn_direction,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending_results,
    output int                    o_steps_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COIL_W-1:0] coil_drive;
        logic              stepped;
        logic              stopped;
        logic              turn_direction;
    } t_tick_result;

    logic [SAMPLE_W-1:0]   high_th;
    logic [SAMPLE_W-1:0]   low_th;
    logic [SAMPLE_W-1:0]   scale;
    logic [CFG_DATA_W-1:0] pattern;
    int unsigned           phase;
    logic [DELAY_W-1:0]    hold_ticks;
    logic [COIL_W-1:0]     coils;
    logic                  ccw;

    t_tick_result predicted_ticks[$];
    int           fails        = 0;
    int           results_seen = 0;
    int           steps        = 0;

    // one tick of the sequencer: hold while a delay runs, else classify the sample
    function automatic t_tick_result advance_motor(input logic [SAMPLE_W-1:0] s);
        t_tick_result        res;
        logic [SAMPLE_W-1:0] excess;
        logic [COIL_W-1:0]   nib;
        logic [31:0]         ticks;
        res    = '0;
        excess = '0;
        if (hold_ticks != '0) begin
            hold_ticks = hold_ticks - 1'b1;
        end else begin
            // clockwise test first, so overlapping thresholds step clockwise
            if (s >= high_th) begin
                ccw         = 1'b0;
                excess      = s - high_th;
                res.stepped = 1'b1;
            end else if (s <= low_th) begin
                ccw         = 1'b1;
                excess      = low_th - s;
                res.stepped = 1'b1;
            end else begin
                res.stopped = 1'b1;
            end
            if (res.stepped) begin
                // nibble picked by phase modulo eight, middle bits crossed onto the port
                nib   = pattern[4*(phase % 8) +: 4];
                coils = {nib[3], nib[1], nib[2], nib[0]};
                if (!ccw)
                    phase = (phase + 1) % PHASE_COUNT;
                else
                    phase = (phase == 0) ? PHASE_COUNT - 1 : phase - 1;
                ticks      = 32'(scale) * 32'(excess) * 32'(excess);
                hold_ticks = (ticks > 32'(DELAY_MAX)) ? DELAY_MAX : ticks[DELAY_W-1:0];
            end
        end
        res.coil_drive     = coils;
        res.turn_direction = ccw;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_tick_result got;
        t_tick_result want;
        if (!i_rst_n) begin
            high_th    = HIGH_TH_RST;
            low_th     = LOW_TH_RST;
            scale      = SCALE_RST;
            pattern    = PATTERN_RST;
            phase      = 0;
            hold_ticks = '0;
            coils      = '0;
            ccw        = 1'b0;
            predicted_ticks.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_HIGH_TH: high_th = i_cfg_data[SAMPLE_W-1:0];
                    CFG_LOW_TH:  low_th  = i_cfg_data[SAMPLE_W-1:0];
                    CFG_SCALE:   scale   = i_cfg_data[SAMPLE_W-1:0];
                    CFG_PATTERN: pattern = i_cfg_data;
                    default: ;
                endcase
            end
            // results are matched before new samples are predicted
            if (i_res_valid && !i_res_stall) begin
                got.coil_drive     = i_res_coil_drive;
                got.stepped        = i_res_stepped;
                got.stopped        = i_res_stopped;
                got.turn_direction = i_res_turn_direction;
                if (i_res_stepped === 1'b1)
                    steps++;
                if (predicted_ticks.size() == 0) begin
                    if (fails < 10)
                        $display({"result %0d arrived with nothing predicted: ",
                                  "coils %h stepped %b stopped %b dir %b"},
                                 results_seen, got.coil_drive, got.stepped, got.stopped,
                                 got.turn_direction);
                    fails++;
                end else begin
                    want = predicted_ticks.pop_front();
                    if (got.coil_drive !== want.coil_drive || got.stepped !== want.stepped ||
                        got.stopped !== want.stopped ||
                        got.turn_direction !== want.turn_direction) begin
                        if (fails < 10)
                            $display({"result %0d mismatch: ",
                                      "want coils %h stepped %b stopped %b dir %b, ",
                                      "got coils %h stepped %b stopped %b dir %b"},
                                     results_seen, want.coil_drive, want.stepped,
                                     want.stopped, want.turn_direction, got.coil_drive,
                                     got.stepped, got.stopped, got.turn_direction);
                        fails++;
                    end
                end
                results_seen++;
            end
            if (i_smp_valid && !i_smp_stall)
                predicted_ticks.push_back(advance_motor(i_smp_data));
        end
        o_fail_count      <= fails;
        o_pending_results <= predicted_ticks.size();
        o_steps_seen      <= steps;
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_joystick_stepper_sequencer_unit.sv -----
// tb_joystick_stepper_sequencer_unit: drives samples, register writes and result back-pressure
// into joystick_stepper_sequencer_unit; checking is done by jss_sequence_checker (uses jss_pkg)
`default_nettype none

module tb_joystick_stepper_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import jss_pkg::*;

    localparam int LIMIT  = 2000;
    localparam int SETTLE = 6;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic [SAMPLE_W-1:0]   i_adc_sample = '0;
    logic                  i_stall      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [COIL_W-1:0]     o_coil_drive;
    logic                  o_stepped;
    logic                  o_stopped;
    logic                  o_turn_direction;

    int fail_count;
    int pending_results;
    int steps_seen;

    bit sender_gaps   = 1'b1;
    bit receiver_gaps = 1'b1;
    bit wide_samples  = 1'b0;
    int cur_high      = 144;
    int cur_low       = 112;
    int offset_max    = 3;
    int stall_left    = 0;
    int idle_cycles   = 0;
    int samples_sent  = 0;
    int settings_applied = 0;

    always #2 i_clk = ~i_clk;

    joystick_stepper_sequencer_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_adc_sample     (i_adc_sample),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_coil_drive     (o_coil_drive),
        .o_stepped        (o_stepped),
        .o_stopped        (o_stopped),
        .o_turn_direction (o_turn_direction),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    jss_sequence_checker checker_i (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_smp_valid          (i_valid),
        .i_smp_stall          (o_stall),
        .i_smp_data           (i_adc_sample),
        .i_res_valid          (o_valid),
        .i_res_stall          (i_stall),
        .i_res_coil_drive     (o_coil_drive),
        .i_res_stepped        (o_stepped),
        .i_res_stopped        (o_stopped),
        .i_res_turn_direction (o_turn_direction),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_fail_count         (fail_count),
        .o_pending_results    (pending_results),
        .o_steps_seen         (steps_seen)
    );

    // result back-pressure in random bursts, counted down in stall_left
    always @(posedge i_clk) begin
        if (!receiver_gaps) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     LIMIT, pending_results);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_sample(input logic [SAMPLE_W-1:0] s);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_adc_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        samples_sent++;
    endtask

    task automatic write_reg(input t_cfg_reg r, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= d;
        @(posedge i_clk);
    endtask

    // registers change only once every result is back and the delay multiply has settled
    task automatic apply_settings(input int h, input int l, input int sc,
                                  input logic [CFG_DATA_W-1:0] pat);
        i_valid <= 1'b0;
        // the outstanding count is registered, so it lags the last transfer
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        write_reg(CFG_HIGH_TH, CFG_DATA_W'(h));
        write_reg(CFG_LOW_TH, CFG_DATA_W'(l));
        write_reg(CFG_SCALE, CFG_DATA_W'(sc));
        write_reg(CFG_PATTERN, pat);
        i_cfg_we <= 1'b0;
        cur_high = h;
        cur_low  = l;
        settings_applied++;
    endtask

    // wide: any value, scale is zero; otherwise short distances keep the hold ticks few
    task automatic pick_settings(input int mode);
        int h;
        int l;
        int sc;
        h = $urandom_range(0, 255);
        if (mode == 0) begin
            wide_samples = 1'b1;
            sc = 0;
            l  = $urandom_range(0, 255);
        end else begin
            wide_samples = 1'b0;
            sc         = (mode == 4) ? 255 : $urandom_range(1, 3);
            offset_max = (mode == 4) ? 1 : 3;
            l = $urandom_range(0, (mode == 4) ? h : ((h + 4 > 255) ? 255 : h + 4));
        end
        apply_settings(h, l, sc, $urandom);
    endtask

    function automatic logic [SAMPLE_W-1:0] next_sample();
        int pick;
        int off;
        pick = $urandom_range(0, 9);
        off  = $urandom_range(0, offset_max);
        if (wide_samples)
            return SAMPLE_W'($urandom);
        if (pick < 4)
            return (cur_high + off > 255) ? 8'd255 : SAMPLE_W'(cur_high + off);
        if (pick < 8)
            return (cur_low < off) ? 8'd0 : SAMPLE_W'(cur_low - off);
        if (cur_high > cur_low + 1)
            return SAMPLE_W'($urandom_range(cur_low + 1, cur_high - 1));
        return SAMPLE_W'(cur_high);
    endfunction

    initial begin
        logic [SAMPLE_W-1:0] directed[$];
        int mode;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: on-threshold steps, dead band, then a hold of ten ticks
        directed = '{8'd144, 8'd112, 8'd128, 8'd113, 8'd143, 8'd145,
                     8'd0, 8'd255, 8'd85, 8'd170, 8'd112, 8'd144, 8'd1, 8'd254,
                     8'd15, 8'd240, 8'd113};
        foreach (directed[k]) push_sample(directed[k]);

        // widest thresholds, largest scale, all coils on
        apply_settings(255, 0, 255, 32'hFFFF_FFFF);
        directed = '{8'd255, 8'd0, 8'd128, 8'd254, 8'd1};
        foreach (directed[k]) push_sample(directed[k]);

        // low above high: clockwise wins
        apply_settings(100, 200, 0, 32'h0000_0000);
        directed = '{8'd150, 8'd50, 8'd250, 8'd100, 8'd200};
        foreach (directed[k]) push_sample(directed[k]);

        for (int ph = 0; ph < 8; ph++) begin
            mode = (ph == 7) ? 0 : (ph == 6) ? $urandom_range(1, 3) : $urandom_range(0, 4);
            pick_settings(mode);
            sender_gaps   <= (ph < 7) && ($urandom_range(0, 3) != 0);
            receiver_gaps <= (ph < 7) && ($urandom_range(0, 3) != 0);
            repeat (80) push_sample(next_sample());
        end

        // scale 64 at distance 64 is one past the counter range, so it must saturate
        apply_settings(100, 50, 64, $urandom);
        push_sample(8'd164);
        repeat (15) push_sample(SAMPLE_W'($urandom));

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (2 * SETTLE) @(posedge i_clk);
        $display("%0d joystick samples over %0d register settings, %0d steps issued",
                 samples_sent, settings_applied, steps_seen);
        $display("covered on-threshold steps, dead band, held delays, crossed thresholds, saturation");
        if (fail_count == 0 && pending_results == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
